[rtl/sps_pkg.sv]
package sps_pkg;

  // Full-scale Q15 divisor is 2^15 - 1
  localparam int unsigned DivShift = 15;
  localparam int unsigned GainDiv  = (1 << DivShift) - 1;

  localparam logic [15:0] MinPulseRst   = 16'd1000;
  localparam logic [15:0] CenterPulseRst = 16'd1500;
  localparam logic [15:0] MaxPulseRst   = 16'd2000;
  localparam logic [14:0] DeadBandRst   = 15'd0;
  localparam logic [15:0] GainRst       = 16'd1000;
  localparam logic [15:0] SlewLimitRst  = 16'd50;
  localparam logic [14:0] DeadBandBad   = 15'h7fff;

  typedef enum logic [2:0] {
    CFG_MIN_PULSE    = 3'd0,
    CFG_CENTER_PULSE = 3'd1,
    CFG_MAX_PULSE    = 3'd2,
    CFG_DEAD_BAND    = 3'd3,
    CFG_GAIN         = 3'd4,
    CFG_SLEW_LIMIT   = 3'd5,
    CFG_INVERT       = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_STEP     = 1'b0,
    OP_RECENTER = 1'b1
  } op_e;

  typedef struct packed {
    logic [15:0] min_pulse;
    logic [15:0] center_pulse;
    logic [15:0] max_pulse;
    logic [14:0] dead_band;
    logic [15:0] gain;
    logic [15:0] slew_limit;
    logic        invert;
  } cfg_t;

  // Move request handed from the move calculation to the target update
  typedef struct packed {
    logic        recenter;
    logic [16:0] used_error;
    logic [17:0] wanted_move;
    logic [16:0] move;
    logic        in_dead_band;
    logic        slew_clamped;
  } move_t;

endpackage

[rtl/sps_step_if.sv]
interface sps_step_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] error_in;

  modport source (output valid, output operation, output error_in, input ready);
  modport sink (input valid, input operation, input error_in, output ready);
endinterface

[rtl/sps_result_if.sv]
interface sps_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  logic [16:0] used_error;
  logic [17:0] wanted_move;
  logic [16:0] actual_move;
  logic        in_dead_band;
  logic        slew_clamped;
  logic        at_limit;
  logic        accepted;
  logic [31:0] steps_total;
  logic [31:0] dead_band_total;
  logic [31:0] slew_total;
  logic [31:0] limit_total;

  modport source (
    output valid, output position, output used_error, output wanted_move,
    output actual_move, output in_dead_band, output slew_clamped, output at_limit,
    output accepted, output steps_total, output dead_band_total, output slew_total,
    output limit_total, input ready
  );
  modport sink (
    input valid, input position, input used_error, input wanted_move,
    input actual_move, input in_dead_band, input slew_clamped, input at_limit,
    input accepted, input steps_total, input dead_band_total, input slew_total,
    input limit_total, output ready
  );
endinterface

[rtl/sps_cfg_if.sv]
interface sps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/sps_move_calc.sv]
module sps_move_calc (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sps_pkg::cfg_t  cfg_i,
  sps_step_if.sink       step_i,
  output logic           move_valid_o,
  input  logic           move_ready_i,
  output sps_pkg::move_t move_o
);
  import sps_pkg::*;

  // Stage 1: input register
  logic        s1_valid_q;
  logic        s1_op_q;
  logic [15:0] s1_err_q;
  // Stage 2: product register
  logic        s2_valid_q;
  logic        s2_recenter_q;
  logic [16:0] s2_err_q;
  logic        s2_dz_q;
  logic [31:0] s2_prod_q;
  // Stage 3: move register
  logic        s3_valid_q;
  move_t       s3_move_q;

  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready     = !s3_valid_q || move_ready_i;
  assign s2_ready     = !s2_valid_q || s3_ready;
  assign s1_ready     = !s1_valid_q || s2_ready;
  assign step_i.ready = s1_ready;

  // Inversion, dead zone test and gain multiply
  logic [16:0] err_ext, err_used, err_neg;
  logic [15:0] err_mag;
  logic        dz_d;
  logic [31:0] prod_d;

  always_comb begin
    err_ext  = {s1_err_q[15], s1_err_q};
    err_neg  = 17'(~err_ext + 17'd1);
    err_used = cfg_i.invert ? err_neg : err_ext;
    err_mag  = err_used[16] ? 16'(~err_used + 17'd1) : err_used[15:0];
    dz_d     = (err_mag <= {1'b0, cfg_i.dead_band});
    prod_d   = 32'(err_mag) * 32'(cfg_i.gain);
  end

  // Divide by 2^15 - 1 through two fold-back steps and one correction
  logic [16:0] q1;
  logic [17:0] r1;
  logic [2:0]  q2;
  logic [15:0] r2;
  logic        corr;
  logic [16:0] quo, mag_q;
  logic        slewed;
  logic [15:0] mv_mag;
  logic [17:0] wanted_pos;
  logic [16:0] move_pos;
  move_t       move_d;

  always_comb begin
    q1         = s2_prod_q[31:DivShift];
    r1         = {3'b000, s2_prod_q[DivShift-1:0]} + {1'b0, q1};
    q2         = r1[17:DivShift];
    r2         = {1'b0, r1[DivShift-1:0]} + {13'd0, q2};
    corr       = (r2 >= 16'(GainDiv));
    quo        = q1 + {14'd0, q2} + {16'd0, corr};
    mag_q      = (quo == 17'd0) ? 17'd1 : quo;
    slewed     = (mag_q > {1'b0, cfg_i.slew_limit});
    mv_mag     = slewed ? cfg_i.slew_limit : mag_q[15:0];
    wanted_pos = {1'b0, mag_q};
    move_pos   = {1'b0, mv_mag};

    move_d              = '0;
    move_d.recenter     = s2_recenter_q;
    if (s2_recenter_q) begin
      move_d.in_dead_band = 1'b1;
    end else if (s2_dz_q) begin
      move_d.used_error   = s2_err_q;
      move_d.in_dead_band = 1'b1;
    end else begin
      move_d.used_error   = s2_err_q;
      move_d.wanted_move  = s2_err_q[16] ? 18'(~wanted_pos + 18'd1) : wanted_pos;
      move_d.move         = s2_err_q[16] ? 17'(~move_pos + 17'd1) : move_pos;
      move_d.slew_clamped = slewed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= step_i.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && step_i.valid) begin
      s1_op_q  <= step_i.operation;
      s1_err_q <= step_i.error_in;
    end
    if (s2_ready && s1_valid_q) begin
      s2_recenter_q <= (s1_op_q == OP_RECENTER);
      s2_err_q      <= err_used;
      s2_dz_q       <= dz_d;
      s2_prod_q     <= prod_d;
    end
    if (s3_ready && s2_valid_q) begin
      s3_move_q <= move_d;
    end
  end

  assign move_valid_o = s3_valid_q;
  assign move_o       = s3_move_q;

endmodule

[rtl/servo_axis_position_stepper.sv]
// A request passes through the input, product, move and result registers in that
// order before its result loads.
// Throughput: one request per cycle while result_o.ready does not hold the flow; the
// target update is the only loop and closes in a single add and range clamp.
// Reset clears all valid flags and counters, loads the register defaults and
// puts the target at the default centre.
module servo_axis_position_stepper (
  input logic           clk_i,
  input logic           rst_ni,
  sps_step_if.sink      step_i,
  sps_result_if.source  result_o,
  sps_cfg_if.sink       cfg_i
);
  import sps_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse    <= MinPulseRst;
      cfg_q.center_pulse <= CenterPulseRst;
      cfg_q.max_pulse    <= MaxPulseRst;
      cfg_q.dead_band    <= DeadBandRst;
      cfg_q.gain         <= GainRst;
      cfg_q.slew_limit   <= SlewLimitRst;
      cfg_q.invert       <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MIN_PULSE:    cfg_q.min_pulse    <= cfg_i.data;
        CFG_CENTER_PULSE: cfg_q.center_pulse <= cfg_i.data;
        CFG_MAX_PULSE:    cfg_q.max_pulse    <= cfg_i.data;
        CFG_DEAD_BAND:    cfg_q.dead_band    <= cfg_i.data[14:0];
        CFG_GAIN:         cfg_q.gain         <= cfg_i.data;
        CFG_SLEW_LIMIT:   cfg_q.slew_limit   <= cfg_i.data;
        CFG_INVERT:       cfg_q.invert       <= cfg_i.data[0];
        default:          ;
      endcase
    end
  end

  logic  mv_valid, mv_ready;
  move_t mv;

  sps_move_calc u_move_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .step_i       (step_i),
    .move_valid_o (mv_valid),
    .move_ready_i (mv_ready),
    .move_o       (mv)
  );

  logic        out_valid_q;
  logic [15:0] target_q;
  logic [31:0] step_cnt_q, dz_cnt_q, slew_cnt_q, limit_cnt_q;
  logic [16:0] used_err_q;
  logic [17:0] wanted_q;
  logic [16:0] actual_q;
  logic        in_dz_q, slewed_q, at_limit_q, accepted_q;

  logic        res_load;
  logic        cfg_ok;
  logic [17:0] sum;
  logic        below, above, blocked;
  logic [15:0] target_d;

  assign mv_ready = !out_valid_q || result_o.ready;
  assign res_load = mv_valid && mv_ready;

  always_comb begin
    cfg_ok = (cfg_q.min_pulse < cfg_q.center_pulse) &&
             (cfg_q.center_pulse < cfg_q.max_pulse) &&
             (cfg_q.dead_band != DeadBandBad) &&
             (cfg_q.gain != 16'd0) && (cfg_q.slew_limit != 16'd0);
    sum     = {2'b00, target_q} + {mv.move[16], mv.move};
    below   = $signed(sum) < $signed({2'b00, cfg_q.min_pulse});
    above   = $signed(sum) > $signed({2'b00, cfg_q.max_pulse});
    blocked = 1'b0;
    priority if (!cfg_ok) begin
      target_d = target_q;
    end else if (mv.recenter) begin
      target_d = cfg_q.center_pulse;
    end else if (below) begin
      target_d = cfg_q.min_pulse;
      blocked  = mv.move[16];
    end else if (above) begin
      target_d = cfg_q.max_pulse;
      blocked  = !mv.move[16] && (mv.move != 17'd0);
    end else begin
      target_d = sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      target_q    <= CenterPulseRst;
      step_cnt_q  <= '0;
      dz_cnt_q    <= '0;
      slew_cnt_q  <= '0;
      limit_cnt_q <= '0;
    end else begin
      if (mv_ready) out_valid_q <= mv_valid;
      if (res_load) begin
        target_q <= target_d;
        if (cfg_ok && !mv.recenter) begin
          step_cnt_q  <= step_cnt_q + 32'd1;
          if (mv.in_dead_band) dz_cnt_q    <= dz_cnt_q + 32'd1;
          if (mv.slew_clamped) slew_cnt_q  <= slew_cnt_q + 32'd1;
          if (blocked)         limit_cnt_q <= limit_cnt_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      accepted_q <= cfg_ok;
      actual_q   <= {1'b0, target_d} - {1'b0, target_q};
      if (cfg_ok) begin
        used_err_q <= mv.used_error;
        wanted_q   <= mv.wanted_move;
        in_dz_q    <= mv.in_dead_band;
        slewed_q   <= mv.slew_clamped;
        at_limit_q <= blocked;
      end else begin
        used_err_q <= '0;
        wanted_q   <= '0;
        in_dz_q    <= 1'b0;
        slewed_q   <= 1'b0;
        at_limit_q <= 1'b0;
      end
    end
  end

  // Target and counters change only when a result loads, so they drive the port
  assign result_o.valid           = out_valid_q;
  assign result_o.position        = target_q;
  assign result_o.used_error      = used_err_q;
  assign result_o.wanted_move     = wanted_q;
  assign result_o.actual_move     = actual_q;
  assign result_o.in_dead_band    = in_dz_q;
  assign result_o.slew_clamped    = slewed_q;
  assign result_o.at_limit        = at_limit_q;
  assign result_o.accepted        = accepted_q;
  assign result_o.steps_total     = step_cnt_q;
  assign result_o.dead_band_total = dz_cnt_q;
  assign result_o.slew_total      = slew_cnt_q;
  assign result_o.limit_total     = limit_cnt_q;

  a_target_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && cfg_ok && !mv.recenter) |=>
      (target_q >= $past(cfg_q.min_pulse)) && (target_q <= $past(cfg_q.max_pulse)))
    else $error("target left the allowed range after a step");

  a_invalid_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && !cfg_ok) |=> $stable(target_q) && $stable(step_cnt_q) && !accepted_q)
    else $error("rejected request changed the state");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && cfg_ok && !mv.recenter) |=> (step_cnt_q == $past(step_cnt_q) + 32'd1))
    else $error("step counter missed an accepted step");

  a_slew_outside_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && slewed_q) |-> (!in_dz_q && accepted_q))
    else $error("slew clamp flagged inside the dead zone");

endmodule

[dv/tb_servo_axis_position_stepper.sv]
`timescale 1ns / 100ps

module tb_servo_axis_position_stepper;
  import sps_pkg::*;

  localparam int DrainCycles = 8;
  localparam int PhaseSize   = 50;
  localparam int PhaseCount  = 17;
  localparam int LimitNs     = 2_000_000;
  localparam logic [2:0] CfgUnused = 3'd7;

  typedef struct packed {
    op_e         op;
    logic [15:0] err;
  } step_req_t;

  typedef struct packed {
    logic [15:0] position;
    logic [16:0] used_error;
    logic [17:0] wanted_move;
    logic [16:0] actual_move;
    logic        in_dead_band;
    logic        slew_clamped;
    logic        at_limit;
    logic        accepted;
    logic [31:0] steps_total;
    logic [31:0] dead_band_total;
    logic [31:0] slew_total;
    logic [31:0] limit_total;
  } servo_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        st_valid = 1'b0;
  op_e         st_op = OP_STEP;
  logic [15:0] st_err = '0;
  logic        rd_ready = 1'b0;
  logic        wr_valid = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [15:0] wr_data = '0;

  sps_step_if   step_if ();
  sps_result_if res_if ();
  sps_cfg_if    cfg_if ();

  assign step_if.valid     = st_valid;
  assign step_if.operation = st_op;
  assign step_if.error_in  = st_err;
  assign res_if.ready      = rd_ready;
  assign cfg_if.valid      = wr_valid;
  assign cfg_if.index      = wr_index;
  assign cfg_if.data       = wr_data;

  servo_axis_position_stepper u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Axis state as the block should hold it
  cfg_t axis_cfg = '{min_pulse: MinPulseRst, center_pulse: CenterPulseRst,
                     max_pulse: MaxPulseRst, dead_band: DeadBandRst, gain: GainRst,
                     slew_limit: SlewLimitRst, invert: 1'b0};
  logic [15:0] axis_target = CenterPulseRst;
  logic [31:0] n_steps = '0;
  logic [31:0] n_dead = '0;
  logic [31:0] n_slew = '0;
  logic [31:0] n_limit = '0;

  step_req_t     step_requests[$];
  servo_result_t due_moves[$];
  int items_pushed = 0;
  int items_taken = 0;
  int bad_moves = 0;

  function automatic servo_result_t advance_axis(op_e op, logic [15:0] raw);
    servo_result_t r;
    longint e, want, mv, oldt, newt, lim, lo, hi;
    bit dz, slewed, blocked, ok;
    r = '0;
    e = longint'($signed(raw));
    want = 0;
    mv = 0;
    dz = 1'b0;
    slewed = 1'b0;
    blocked = 1'b0;
    oldt = longint'(axis_target);
    newt = oldt;
    lo = longint'(axis_cfg.min_pulse);
    hi = longint'(axis_cfg.max_pulse);
    ok = (axis_cfg.min_pulse < axis_cfg.center_pulse) &&
         (axis_cfg.center_pulse < axis_cfg.max_pulse) &&
         (axis_cfg.dead_band != DeadBandBad) && (axis_cfg.gain != '0) &&
         (axis_cfg.slew_limit != '0);
    if (ok) begin
      if (op == OP_RECENTER) begin
        e = 0;
        dz = 1'b1;
        newt = longint'(axis_cfg.center_pulse);
      end else begin
        lim = longint'(axis_cfg.slew_limit);
        if (axis_cfg.invert) begin
          e = -e;
        end
        dz = ((e < 0) ? -e : e) <= longint'(axis_cfg.dead_band);
        if (!dz) begin
          want = (e * longint'(axis_cfg.gain)) / longint'(GainDiv);
          if (want == 0) begin
            want = (e > 0) ? 1 : -1;
          end
          mv = want;
          if (mv < -lim) begin
            mv = -lim;
          end else if (mv > lim) begin
            mv = lim;
          end
          slewed = (mv != want);
        end
        newt = oldt + mv;
        // Clamp into range; flag a block only when the move pointed at that bound
        if (newt < lo) begin
          newt = lo;
          blocked = (mv < 0);
        end else if (newt > hi) begin
          newt = hi;
          blocked = (mv > 0);
        end
        n_steps = n_steps + 1;
        if (dz) n_dead = n_dead + 1;
        if (slewed) n_slew = n_slew + 1;
        if (blocked) n_limit = n_limit + 1;
      end
      r.actual_move = 17'(newt - oldt);
      axis_target = 16'(newt);
    end else begin
      e = 0;
    end
    r.position        = axis_target;
    r.used_error      = 17'(e);
    r.wanted_move     = 18'(want);
    r.in_dead_band    = dz;
    r.slew_clamped    = slewed;
    r.at_limit        = blocked;
    r.accepted        = ok;
    r.steps_total     = n_steps;
    r.dead_band_total = n_dead;
    r.slew_total      = n_slew;
    r.limit_total     = n_limit;
    return r;
  endfunction

  // Request driver: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_steps
    step_req_t nxt;
    if (!rst_ni) begin
      st_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (st_valid && step_if.ready) begin
        due_moves.push_back(advance_axis(st_op, st_err));
        items_taken <= items_taken + 1;
      end
      if (!st_valid || step_if.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          st_valid <= 1'b0;
        end else if (step_requests.size() == 0) begin
          st_valid <= 1'b0;
        end else begin
          nxt = step_requests.pop_front();
          st_valid <= 1'b1;
          st_op <= nxt.op;
          st_err <= nxt.err;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Result monitor: ready follows a rotating pattern, reloaded now and then
  logic [15:0] ready_pat = '1;
  int pat_age = 0;

  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    servo_result_t got, want;
    if (!rst_ni) begin
      rd_ready <= 1'b0;
      ready_pat <= '1;
      pat_age <= 0;
    end else begin
      rd_ready <= ready_pat[0];
      if (pat_age == 199) begin
        pat_age <= 0;
        ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0101);
      end else begin
        pat_age <= pat_age + 1;
        ready_pat <= {ready_pat[0], ready_pat[15:1]};
      end
      if (res_if.valid && rd_ready) begin
        got = '{res_if.position, res_if.used_error, res_if.wanted_move,
                res_if.actual_move, res_if.in_dead_band, res_if.slew_clamped,
                res_if.at_limit, res_if.accepted, res_if.steps_total,
                res_if.dead_band_total, res_if.slew_total, res_if.limit_total};
        if (due_moves.size() == 0) begin
          bad_moves = bad_moves + 1;
          if (bad_moves <= 10) begin
            $display("%0t: result with no request outstanding, position %0d", $realtime,
                     got.position);
          end
        end else begin
          want = due_moves.pop_front();
          if (got != want) begin
            bad_moves = bad_moves + 1;
            if (bad_moves <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  want pos=%0d err=%0d wmv=%0d amv=%0d dz=%b sl=%b lim=%b acc=%b cnt=%0d/%0d/%0d/%0d",
                       want.position, $signed(want.used_error), $signed(want.wanted_move),
                       $signed(want.actual_move), want.in_dead_band, want.slew_clamped,
                       want.at_limit, want.accepted, want.steps_total,
                       want.dead_band_total, want.slew_total, want.limit_total);
              $display("  got  pos=%0d err=%0d wmv=%0d amv=%0d dz=%b sl=%b lim=%b acc=%b cnt=%0d/%0d/%0d/%0d",
                       got.position, $signed(got.used_error), $signed(got.wanted_move),
                       $signed(got.actual_move), got.in_dead_band, got.slew_clamped,
                       got.at_limit, got.accepted, got.steps_total,
                       got.dead_band_total, got.slew_total, got.limit_total);
            end
          end
        end
      end
    end
  end

  task automatic queue_step(op_e op, logic [15:0] err);
    step_requests.push_back('{op: op, err: err});
    items_pushed = items_pushed + 1;
  endtask

  // Wait for every request to come back, then let the pipeline drain
  task automatic settle_axis();
    do @(negedge clk_i); while (items_taken != items_pushed || due_moves.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write every register back to back; call at a rising edge while idle
  task automatic program_regs(cfg_t c, bit poke_unused);
    logic [2:0]  idx_list[8];
    logic [15:0] data_list[8];
    int n;
    idx_list[0] = CFG_MIN_PULSE;    data_list[0] = c.min_pulse;
    idx_list[1] = CFG_CENTER_PULSE; data_list[1] = c.center_pulse;
    idx_list[2] = CFG_MAX_PULSE;    data_list[2] = c.max_pulse;
    idx_list[3] = CFG_DEAD_BAND;    data_list[3] = {1'($urandom_range(0, 1)), c.dead_band};
    idx_list[4] = CFG_GAIN;         data_list[4] = c.gain;
    idx_list[5] = CFG_SLEW_LIMIT;   data_list[5] = c.slew_limit;
    idx_list[6] = CFG_INVERT;       data_list[6] = {15'($urandom), c.invert};
    idx_list[7] = CfgUnused;        data_list[7] = 16'($urandom);
    n = poke_unused ? 8 : 7;
    for (int i = 0; i < n; i++) begin
      wr_valid <= 1'b1;
      wr_index <= idx_list[i];
      wr_data <= data_list[i];
      do @(posedge clk_i); while (!cfg_if.ready);
      case (idx_list[i])
        CFG_MIN_PULSE:    axis_cfg.min_pulse = data_list[i];
        CFG_CENTER_PULSE: axis_cfg.center_pulse = data_list[i];
        CFG_MAX_PULSE:    axis_cfg.max_pulse = data_list[i];
        CFG_DEAD_BAND:    axis_cfg.dead_band = data_list[i][14:0];
        CFG_GAIN:         axis_cfg.gain = data_list[i];
        CFG_SLEW_LIMIT:   axis_cfg.slew_limit = data_list[i];
        CFG_INVERT:       axis_cfg.invert = data_list[i][0];
        default: ;
      endcase
    end
    wr_valid <= 1'b0;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    int unsigned lo, hi;
    c.invert = 1'($urandom_range(0, 1));
    c.dead_band = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                              : 15'($urandom_range(0, 600));
    c.gain = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4000));
    c.slew_limit = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
    lo = $urandom_range(0, 40000);
    hi = lo + $urandom_range(2, 8000);
    c.min_pulse = 16'(lo);
    c.max_pulse = 16'(hi);
    c.center_pulse = 16'($urandom_range(lo + 1, hi - 1));
    case ($urandom_range(0, 9))
      0: begin
        c.min_pulse = '0;
        c.max_pulse = '1;
        c.center_pulse = 16'($urandom_range(1, 65534));
        c.gain = '1;
        c.slew_limit = '1;
        c.dead_band = '0;
      end
      1: begin
        c.gain = 16'd1;
        c.slew_limit = 16'd1;
        c.dead_band = DeadBandBad - 15'd1;
      end
      2: begin
        // Break one rule so the block must refuse every request
        case ($urandom_range(0, 4))
          0: c.gain = '0;
          1: c.slew_limit = '0;
          2: c.dead_band = DeadBandBad;
          3: c.center_pulse = c.min_pulse;
          default: c.center_pulse = c.max_pulse;
        endcase
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] rand_error(logic [14:0] db);
    int m;
    case ($urandom_range(0, 7))
      0, 1, 2: return 16'($urandom);
      3: begin
        m = int'(db) + int'($urandom_range(0, 6)) - 3;
        if (m < 0) m = 0;
        if (m > 32767) m = 32767;
      end
      4: m = $urandom_range(0, 40);
      5: begin
        case ($urandom_range(0, 2))
          0: return 16'h8000;
          1: return 16'h7fff;
          default: return 16'h8001;
        endcase
      end
      default: m = $urandom_range(0, 4000);
    endcase
    return ($urandom_range(0, 1) != 0) ? 16'(-m) : 16'(m);
  endfunction

  initial begin : stimulus
    cfg_t c;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults: zero error, forced unit moves, full scale both ways, recentre
    @(negedge clk_i);
    queue_step(OP_STEP, 16'h0000);
    queue_step(OP_STEP, 16'h0001);
    queue_step(OP_STEP, 16'hffff);
    queue_step(OP_STEP, 16'd10);
    queue_step(OP_STEP, 16'h7fff);
    queue_step(OP_STEP, 16'h8000);
    queue_step(OP_RECENTER, 16'h1234);
    settle_axis();

    // Widest range, largest gain and slew, inverted: most negative error flips positive
    c = '{min_pulse: 16'd0, center_pulse: 16'd1, max_pulse: 16'hffff, dead_band: 15'd100,
          gain: 16'hffff, slew_limit: 16'hffff, invert: 1'b1};
    program_regs(c, 1'b1);
    @(negedge clk_i);
    queue_step(OP_STEP, 16'h8000);
    queue_step(OP_STEP, 16'd100);
    queue_step(OP_STEP, -16'sd101);
    queue_step(OP_STEP, 16'd101);
    queue_step(OP_RECENTER, 16'h0000);
    settle_axis();

    // Range moved above the held target: next steps pull it back in
    c = '{min_pulse: 16'd65533, center_pulse: 16'd65534, max_pulse: 16'hffff,
          dead_band: DeadBandBad - 15'd1, gain: 16'd1, slew_limit: 16'd1, invert: 1'b0};
    program_regs(c, 1'b0);
    @(negedge clk_i);
    queue_step(OP_STEP, 16'h7fff);
    queue_step(OP_STEP, 16'h8000);
    queue_step(OP_STEP, 16'd5);
    settle_axis();

    // Dead band at its invalid value: both operations refused
    c.dead_band = DeadBandBad;
    program_regs(c, 1'b0);
    @(negedge clk_i);
    queue_step(OP_STEP, 16'd1000);
    queue_step(OP_RECENTER, 16'h0000);
    settle_axis();

    for (int p = 0; p < PhaseCount; p++) begin
      c = random_cfg();
      program_regs(c, $urandom_range(0, 3) == 0);
      @(negedge clk_i);
      for (int i = 0; i < PhaseSize; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_step(OP_RECENTER, 16'($urandom));
        end else begin
          queue_step(OP_STEP, rand_error(c.dead_band));
        end
      end
      settle_axis();
    end

    if (bad_moves == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(LimitNs);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
